// ===== rtl/assert_macros.svh =====
// assertion helpers for the dequant block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is low
`define DQS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define DQS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dqs_pkg.sv =====
package dqs_pkg;

   // operand class carried beside the datapath
   typedef enum logic [1:0] {
      CLS_NUM  = 2'd0,
      CLS_ZERO = 2'd1,
      CLS_INF  = 2'd2,
      CLS_NAN  = 2'd3
   } cls_type;

   typedef struct packed {
      logic    sign;
      cls_type cls;
   } side_type;

   // half operand widened: value = man * 2^(exp-10), man in [2^10, 2^11)
   typedef struct packed {
      logic [10:0]        man;
      logic signed [7:0]  exp;
   } hflt_type;

   // single operand: value = man * 2^(exp-23), man in [2^23, 2^24)
   typedef struct packed {
      logic [23:0]        man;
      logic signed [7:0]  exp;
      side_type           side;
   } flt_type;

   typedef struct packed {
      logic [23:0]        a_man;
      logic signed [7:0]  a_exp;
      hflt_type           b;
      side_type           side;
   } mul_op_type;

   localparam logic [15:0] ACT_RESET  = 16'h3C00;
   localparam logic [15:0] HALF_QNAN  = 16'h7E00;
   localparam logic [14:0] HALF_INF   = 15'h7C00;
   localparam int          HALF_BIAS  = 15;

   // widen a half bit pattern, subnormals normalized
   function automatic hflt_type half_decode(input logic [15:0] h);
      hflt_type   r;
      logic [3:0] k;
      r.man = {1'b1, h[9:0]};
      r.exp = $signed({3'b000, h[14:10]}) - 8'(HALF_BIAS);
      k = 4'd0;
      if (h[14:10] == 5'd0) begin
         for (int i = 0; i < 10; i++) begin
            if (h[i]) begin
               k = 4'(i);
            end
         end
         r.man = 11'({1'b0, h[9:0]} << (4'd10 - k));
         r.exp = $signed({4'b0000, k}) - 8'sd24;
      end
      return r;
   endfunction

   function automatic cls_type half_class(input logic [15:0] h);
      cls_type c;
      c = CLS_NUM;
      if (h[14:10] == 5'h1F) begin
         c = (h[9:0] != 10'd0) ? CLS_NAN : CLS_INF;
      end else if (h[14:0] == 15'd0) begin
         c = CLS_ZERO;
      end
      return c;
   endfunction

endpackage

// ===== rtl/dqs_front.sv =====
module dqs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         acc,
   input  logic [15:0]         ws,
   input  logic [15:0]         act,
   output logic                out_valid,
   input  logic                out_ready,
   output dqs_pkg::mul_op_type out_op
);
   import dqs_pkg::*;

   logic        v1_ff, v2_ff, v3_ff;
   logic        rdy1, rdy2, rdy3;
   logic [31:0] abs1_ff, abs2_ff;
   logic [4:0]  lz2_ff;
   hflt_type    w1_ff, w2_ff;
   side_type    side1_ff, side2_ff;
   mul_op_type  op3_ff;

   logic [31:0] abs_in;
   side_type    side_in;
   logic [4:0]  lz_in;
   mul_op_type  op_in;

   cls_type     wcls, xcls;
   logic        accz, pnan, pinf, pzero, rnan, rinf, rzero;
   logic [31:0] norm;
   logic        rinc;
   logic [24:0] msum;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // magnitude and result class
   always_comb begin
      abs_in  = acc[31] ? (32'd0 - acc) : acc;
      wcls    = half_class(ws);
      xcls    = half_class(act);
      accz    = (acc == 32'd0);
      pnan    = (wcls == CLS_NAN) || (accz && wcls == CLS_INF);
      pinf    = (wcls == CLS_INF) && !accz;
      pzero   = !pnan && (accz || wcls == CLS_ZERO);
      rnan    = pnan || (xcls == CLS_NAN) || (pzero && xcls == CLS_INF)
                || (pinf && xcls == CLS_ZERO);
      rinf    = !rnan && (pinf || xcls == CLS_INF);
      rzero   = !rnan && !rinf && (pzero || xcls == CLS_ZERO);
      side_in.sign = acc[31] ^ ws[15] ^ act[15];
      if (rnan) begin
         side_in.cls = CLS_NAN;
      end else if (rinf) begin
         side_in.cls = CLS_INF;
      end else if (rzero) begin
         side_in.cls = CLS_ZERO;
      end else begin
         side_in.cls = CLS_NUM;
      end
   end

   // leading zero count
   always_comb begin
      lz_in = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (abs1_ff[i]) begin
            lz_in = 5'(31 - i);
         end
      end
   end

   // normalize and round to 24 bits
   always_comb begin
      norm  = abs2_ff << lz2_ff;
      rinc  = norm[7] && ((|norm[6:0]) || norm[8]);
      msum  = {1'b0, norm[31:8]} + {24'd0, rinc};
      op_in.a_man = msum[24] ? 24'h800000 : msum[23:0];
      op_in.a_exp = $signed({3'b000, ~lz2_ff}) + $signed({7'd0, msum[24]});
      op_in.b     = w2_ff;
      op_in.side  = side2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         abs1_ff  <= abs_in;
         w1_ff    <= half_decode(ws);
         side1_ff <= side_in;
      end
      if (rdy2 && v1_ff) begin
         abs2_ff  <= abs1_ff;
         lz2_ff   <= lz_in;
         w2_ff    <= w1_ff;
         side2_ff <= side1_ff;
      end
      if (rdy3 && v2_ff) begin
         op3_ff <= op_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_op    = op3_ff;

endmodule

// ===== rtl/dqs_fmul.sv =====
module dqs_fmul (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dqs_pkg::mul_op_type in_op,
   output logic                out_valid,
   input  logic                out_ready,
   output dqs_pkg::flt_type    out_flt
);
   import dqs_pkg::*;

   logic              v1_ff, v2_ff;
   logic              rdy1, rdy2;
   logic [34:0]       prod1_ff;
   logic signed [7:0] exp1_ff;
   side_type          side1_ff;
   flt_type           flt2_ff;

   logic [23:0]       m;
   logic              g, s, rinc;
   logic [24:0]       msum;
   logic signed [7:0] e;
   flt_type           flt_in;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // normalize the 35-bit product and round to nearest even
   always_comb begin
      if (prod1_ff[34]) begin
         m = prod1_ff[34:11];
         g = prod1_ff[10];
         s = |prod1_ff[9:0];
         e = exp1_ff + 8'sd1;
      end else begin
         m = prod1_ff[33:10];
         g = prod1_ff[9];
         s = |prod1_ff[8:0];
         e = exp1_ff;
      end
      rinc = g && (s || m[0]);
      msum = {1'b0, m} + {24'd0, rinc};
      flt_in.man  = msum[24] ? 24'h800000 : msum[23:0];
      flt_in.exp  = e + $signed({7'd0, msum[24]});
      flt_in.side = side1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   // multiply stage, then rounding stage
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         prod1_ff <= 35'(in_op.a_man) * 35'(in_op.b.man);
         exp1_ff  <= in_op.a_exp + in_op.b.exp;
         side1_ff <= in_op.side;
      end
      if (rdy2 && v1_ff) begin
         flt2_ff <= flt_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_flt   = flt2_ff;

endmodule

// ===== rtl/dqs_hpack.sv =====
module dqs_hpack (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dqs_pkg::flt_type in_flt,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [15:0]      out_half
);
   import dqs_pkg::*;

   logic        v1_ff, v2_ff;
   logic        rdy1, rdy2;
   logic [14:0] q1_ff;
   logic        g1_ff, s1_ff, ovf1_ff;
   side_type    side1_ff;
   logic [15:0] half2_ff;

   logic signed [8:0] ue, shf;
   logic [4:0]        sh;
   logic [47:0]       ext;
   logic [14:0]       q_in;
   logic              g_in, s_in, ovf_in, rinc;
   logic [15:0]       half_in;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // split into kept bits, guard and sticky at half precision
   always_comb begin
      ue     = 9'(in_flt.exp) + 9'sd15;
      shf    = -9'sd1 - 9'(in_flt.exp);
      sh     = (shf > 9'sd25) ? 5'd25 : shf[4:0];
      ext    = {in_flt.man, 24'd0} >> sh;
      ovf_in = (ue >= 9'sd31);
      if (ue >= 9'sd1) begin
         q_in = {ue[4:0], in_flt.man[22:13]};
         g_in = in_flt.man[12];
         s_in = |in_flt.man[11:0];
      end else begin
         q_in = ext[38:24];
         g_in = ext[23];
         s_in = |ext[22:0];
      end
   end

   // round and pick special encodings
   always_comb begin
      rinc = g1_ff && (s1_ff || q1_ff[0]);
      case (side1_ff.cls)
         CLS_NAN:  half_in = HALF_QNAN;
         CLS_INF:  half_in = {side1_ff.sign, HALF_INF};
         CLS_ZERO: half_in = {side1_ff.sign, 15'd0};
         default: begin
            if (ovf1_ff) begin
               half_in = {side1_ff.sign, HALF_INF};
            end else begin
               half_in = {side1_ff.sign, q1_ff + {14'd0, rinc}};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         q1_ff    <= q_in;
         g1_ff    <= g_in;
         s1_ff    <= s_in;
         ovf1_ff  <= ovf_in;
         side1_ff <= in_flt.side;
      end
      if (rdy2 && v1_ff) begin
         half2_ff <= half_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_half  = half2_ff;

endmodule

// ===== rtl/int32_to_fp16_dequant_scale_top.sv =====
// int32 accumulator to fp16 dequantization with weight and activation scales
//
// req channel: one beat per element, accumulator (signed) and fp16 weight
//   scale; result = fp16(single(single(acc) * ws) * act), nearest even.
// rsp channel: one fp16 beat per request beat, in order.
// csr channel: writes the fp16 activation scale; always ready. Write it
//   only while no element is in flight.
// registers: an accepted req beat passes nine register stages before
//   rsp_tvalid (3 for int-to-single, 2 per multiply, 2 for the fp16
//   pack).
// throughput: one beat per cycle while the output is not stalled; each stage
//   has its own valid bit and loads when it is empty or the next stage moves.
// reset: clears all valid bits, activation scale returns to 1.0 (0x3C00).
// stall: when rsp_tready is low the pipe keeps filling its empty stages;
//   req_tready drops only once every stage holds a beat. nothing is lost
//   or repeated.
module int32_to_fp16_dequant_scale_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] accumulator, [47:32] weight_scale
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] result_half
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import dqs_pkg::*;
`include "assert_macros.svh"

   logic [15:0] act_ff;
   hflt_type    xs_ff;

   logic        fr_valid, fr_ready, m1_valid, m1_ready, m2_valid, m2_ready;
   mul_op_type  fr_op, m2_op;
   flt_type     m1_flt, m2_flt;

   // activation scale register and its widened copy
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ACT_RESET;
      end else if (csr_valid && csr_ready) begin
         act_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff <= half_decode(act_ff);
   end

   dqs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .acc       (req_tdata[31:0]),
      .ws        (req_tdata[47:32]),
      .act       (act_ff),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_op    (fr_op)
   );

   dqs_fmul u_mul_w (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_op     (fr_op),
      .out_valid (m1_valid),
      .out_ready (m1_ready),
      .out_flt   (m1_flt)
   );

   // second multiply by the activation scale
   always_comb begin
      m2_op.a_man = m1_flt.man;
      m2_op.a_exp = m1_flt.exp;
      m2_op.b     = xs_ff;
      m2_op.side  = m1_flt.side;
   end

   dqs_fmul u_mul_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m1_valid),
      .in_ready  (m1_ready),
      .in_op     (m2_op),
      .out_valid (m2_valid),
      .out_ready (m2_ready),
      .out_flt   (m2_flt)
   );

   dqs_hpack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_valid),
      .in_ready  (m2_ready),
      .in_flt    (m2_flt),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_half  (rsp_tdata)
   );

   // checks
   `DQS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
   `DQS_ASSERT(a_stall_source, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready, "req stalled with free output")
   `DQS_ASSERT(a_nan_canon, clock, reset, rsp_tvalid && rsp_tdata[14:10] == 5'h1F && rsp_tdata[9:0] != 10'd0 |-> rsp_tdata == HALF_QNAN, "non-canonical nan")

endmodule
